>>> rtl/core/ufrr_pkg.sv
// shared types, codes and the crc helper for the uart frame receiver router
package ufrr_pkg;

   // hunt phases of the deframer
   typedef enum logic [2:0] {
      PH_HEAD1 = 3'd0,
      PH_HEAD2 = 3'd1,
      PH_ID    = 3'd2,
      PH_DEST  = 3'd3,
      PH_SRC   = 3'd4,
      PH_LEN   = 3'd5,
      PH_BODY  = 3'd6
   } phase_type;

   // verdict codes carried on the response channel
   typedef enum logic [2:0] {
      VERDICT_CRC_ERROR    = 3'd0,
      VERDICT_WRONG_SOURCE = 3'd1,
      VERDICT_FORWARD      = 3'd2,
      VERDICT_LOCAL        = 3'd3,
      VERDICT_BAD_LENGTH   = 3'd4
   } verdict_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MY_ADDRESS    = 2'd0,
      CSR_HOST_ADDRESS  = 2'd1,
      CSR_HEADER_FIRST  = 2'd2,
      CSR_HEADER_SECOND = 2'd3
   } csr_index_type;

   localparam logic [15:0] CRC_INIT          = 16'hFFFF;
   localparam logic [15:0] CRC_POLY          = 16'hA001;
   localparam logic [7:0]  MIN_LENGTH        = 8'd8;
   localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
   localparam logic [7:0]  HEADER_SECOND_RST = 8'hBB;

   // configuration seen by the deframer
   typedef struct packed {
      logic [7:0] my_address;
      logic [7:0] host_address;
      logic [7:0] header_first;
      logic [7:0] header_second;
   } cfg_type;

   // one response
   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  command_id;
      logic [7:0]  frame_length;
      logic [15:0] crc_received;
      logic [15:0] crc_computed;
   } result_type;

   // crc-16/modbus over one byte, lsb first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/core/ufrr_deframer.sv
// header hunt, field capture, running crc and end of frame verdict
module ufrr_deframer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            in_byte,
   input  ufrr_pkg::cfg_type     cfg,
   output logic                  res_valid,
   output ufrr_pkg::result_type  res
);

   ufrr_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  index_ff, index_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  id_ff, id_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  src_ff, src_in;
   logic [7:0]  crc_low_ff, crc_low_in;

   logic [8:0]  pos_plus_two;
   logic        body_more;
   logic        body_crc_low;
   logic [15:0] crc_cont;
   logic [15:0] crc_start;
   logic [15:0] crc_rcv;

   // shared datapath terms
   assign pos_plus_two = {1'b0, index_ff} + 9'd2;
   assign body_more    = pos_plus_two < {1'b0, len_ff};
   assign body_crc_low = pos_plus_two == {1'b0, len_ff};
   assign crc_cont     = ufrr_pkg::crc16_update(crc_ff, in_byte);
   assign crc_start    = ufrr_pkg::crc16_update(ufrr_pkg::CRC_INIT, in_byte);
   assign crc_rcv      = {in_byte, crc_low_ff};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (in_valid) begin
         case (phase_ff)
            ufrr_pkg::PH_HEAD1: begin
               if (in_byte == cfg.header_first) phase_in = ufrr_pkg::PH_HEAD2;
            end
            ufrr_pkg::PH_HEAD2: begin
               if (in_byte == cfg.header_second) begin
                  phase_in = ufrr_pkg::PH_ID;
               end else if (in_byte == cfg.header_first) begin
                  phase_in = ufrr_pkg::PH_HEAD2;
               end else begin
                  phase_in = ufrr_pkg::PH_HEAD1;
               end
            end
            ufrr_pkg::PH_ID:   phase_in = ufrr_pkg::PH_DEST;
            ufrr_pkg::PH_DEST: phase_in = ufrr_pkg::PH_SRC;
            ufrr_pkg::PH_SRC:  phase_in = ufrr_pkg::PH_LEN;
            ufrr_pkg::PH_LEN: begin
               if (in_byte < ufrr_pkg::MIN_LENGTH) begin
                  phase_in = ufrr_pkg::PH_HEAD1;
               end else begin
                  phase_in = ufrr_pkg::PH_BODY;
               end
            end
            ufrr_pkg::PH_BODY: begin
               if (!body_more && !body_crc_low) phase_in = ufrr_pkg::PH_HEAD1;
            end
            default: phase_in = ufrr_pkg::PH_HEAD1;
         endcase
      end
   end

   // field capture, crc and result
   always_comb begin
      index_in   = index_ff;
      crc_in     = crc_ff;
      len_in     = len_ff;
      id_in      = id_ff;
      dest_in    = dest_ff;
      src_in     = src_ff;
      crc_low_in = crc_low_ff;
      res_valid  = 1'b0;
      res.verdict      = ufrr_pkg::VERDICT_CRC_ERROR;
      res.command_id   = id_ff;
      res.frame_length = len_ff;
      res.crc_received = crc_rcv;
      res.crc_computed = crc_ff;
      if (in_valid) begin
         case (phase_ff)
            ufrr_pkg::PH_HEAD1: begin
               if (in_byte == cfg.header_first) begin
                  crc_in   = crc_start;
                  index_in = 8'd1;
               end
            end
            ufrr_pkg::PH_HEAD2: begin
               if (in_byte == cfg.header_second) begin
                  crc_in   = crc_cont;
                  index_in = index_ff + 8'd1;
               end else if (in_byte == cfg.header_first) begin
                  crc_in   = crc_start;
                  index_in = 8'd1;
               end
            end
            ufrr_pkg::PH_ID: begin
               id_in    = in_byte;
               crc_in   = crc_cont;
               index_in = index_ff + 8'd1;
            end
            ufrr_pkg::PH_DEST: begin
               dest_in  = in_byte;
               crc_in   = crc_cont;
               index_in = index_ff + 8'd1;
            end
            ufrr_pkg::PH_SRC: begin
               src_in   = in_byte;
               crc_in   = crc_cont;
               index_in = index_ff + 8'd1;
            end
            ufrr_pkg::PH_LEN: begin
               len_in = in_byte;
               if (in_byte < ufrr_pkg::MIN_LENGTH) begin
                  // short length: reject and hunt again
                  res_valid        = 1'b1;
                  res.verdict      = ufrr_pkg::VERDICT_BAD_LENGTH;
                  res.frame_length = in_byte;
                  res.crc_received = 16'h0000;
                  res.crc_computed = 16'h0000;
               end else begin
                  crc_in   = crc_cont;
                  index_in = index_ff + 8'd1;
               end
            end
            ufrr_pkg::PH_BODY: begin
               if (body_more) begin
                  crc_in   = crc_cont;
                  index_in = index_ff + 8'd1;
               end else if (body_crc_low) begin
                  crc_low_in = in_byte;
                  index_in   = index_ff + 8'd1;
               end else begin
                  // last byte: crc high byte, judge the frame
                  res_valid = 1'b1;
                  index_in  = 8'd0;
                  if (crc_rcv != crc_ff) begin
                     res.verdict = ufrr_pkg::VERDICT_CRC_ERROR;
                  end else if (src_ff != cfg.host_address) begin
                     res.verdict = ufrr_pkg::VERDICT_WRONG_SOURCE;
                  end else if (dest_ff != cfg.my_address) begin
                     res.verdict = ufrr_pkg::VERDICT_FORWARD;
                  end else begin
                     res.verdict = ufrr_pkg::VERDICT_LOCAL;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= ufrr_pkg::PH_HEAD1;
         index_ff   <= 8'd0;
         crc_ff     <= ufrr_pkg::CRC_INIT;
         len_ff     <= 8'd0;
         id_ff      <= 8'd0;
         dest_ff    <= 8'd0;
         src_ff     <= 8'd0;
         crc_low_ff <= 8'd0;
      end else begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         crc_ff     <= crc_in;
         len_ff     <= len_in;
         id_ff      <= id_in;
         dest_ff    <= dest_in;
         src_ff     <= src_in;
         crc_low_ff <= crc_low_in;
      end
   end

endmodule

>>> rtl/core/ufrr_out_buffer.sv
// two-entry response buffer: output register plus skid register
module ufrr_out_buffer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ufrr_pkg::result_type  in_res,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output ufrr_pkg::result_type  out_res
);

   logic                  main_valid_ff, main_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   ufrr_pkg::result_type  main_ff, main_in;
   ufrr_pkg::result_type  skid_ff, skid_in;
   logic                  pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_res   = main_ff;

   // fill and drain
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_res;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

>>> rtl/core/uart_frame_receiver_router_core.sv
// top level of the uart frame receiver router
// Takes one received byte per request, one per clock when unstalled. The
// deframer hunts for the two sync bytes, captures id, destination, source and
// length, and runs a byte-wide crc-16/modbus update on each accepted
// frame byte up to the crc field. The byte that ends a frame (or a length
// byte below 8) yields one response; it shows on the output in the next
// cycle when the output register is free, otherwise it waits in the skid
// entry until the response ahead of it leaves. Other bytes yield nothing.
// A two-entry response buffer lets requests keep flowing while one response
// waits; req_stall rises only when both entries hold responses. Configuration
// writes take effect at the next clock and belong in idle periods.
module uart_frame_receiver_router_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_verdict,
   output logic [7:0]  rsp_command_id,
   output logic [7:0]  rsp_frame_length,
   output logic [15:0] rsp_crc_received,
   output logic [15:0] rsp_crc_computed,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   ufrr_pkg::cfg_type     cfg_ff;
   ufrr_pkg::result_type  res;
   ufrr_pkg::result_type  rsp_res;
   logic                  accept;
   logic                  res_valid;
   logic                  buf_full;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.my_address    <= 8'd0;
         cfg_ff.host_address  <= 8'd0;
         cfg_ff.header_first  <= ufrr_pkg::HEADER_FIRST_RST;
         cfg_ff.header_second <= ufrr_pkg::HEADER_SECOND_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            ufrr_pkg::CSR_MY_ADDRESS:    cfg_ff.my_address    <= csr_write_data;
            ufrr_pkg::CSR_HOST_ADDRESS:  cfg_ff.host_address  <= csr_write_data;
            ufrr_pkg::CSR_HEADER_FIRST:  cfg_ff.header_first  <= csr_write_data;
            ufrr_pkg::CSR_HEADER_SECOND: cfg_ff.header_second <= csr_write_data;
            default: ;
         endcase
      end
   end

   // frame parsing
   ufrr_deframer u_deframer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // response buffering
   ufrr_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (rsp_res)
   );

   // response fields
   assign rsp_verdict      = rsp_res.verdict;
   assign rsp_command_id   = rsp_res.command_id;
   assign rsp_frame_length = rsp_res.frame_length;
   assign rsp_crc_received = rsp_res.crc_received;
   assign rsp_crc_computed = rsp_res.crc_computed;

   // a full buffer always presents a response
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("buffer full without a response on the output");

   // responses come only from accepted requests
   assert property (@(posedge clock) disable iff (reset) res_valid |-> accept)
      else $error("response produced without an accepted request");

   // a new response behind a stalled one lands in the skid entry
   assert property (@(posedge clock) disable iff (reset)
      res_valid && rsp_valid && rsp_stall |=> req_stall)
      else $error("response behind a stalled output was not held");

endmodule
